@@ design/ptrc_pkg.sv @@
// ============================================================================
// PWM timing register calculator - shared definitions
// Widths, scaling constants and status codes used by the calculator.
// ============================================================================
package ptrc_pkg;

    // Search limits
    localparam int MAX_SHIFT  = 12;
    localparam int COUNT_MAX  = 1023;

    // Field widths
    localparam int CLK_W      = 30;
    localparam int NS_W       = 32;
    localparam int STATUS_W   = 2;
    localparam int PCOUNT_W   = 10;
    localparam int DCOUNT_W   = 16;
    localparam int SHIFT_W    = 4;
    localparam int CTRL_W     = 2;

    // Internal datapath widths
    localparam int BASE_W     = 24;  // clock / 100 fits below 2^24
    localparam int TICK_W     = 30;  // tick in 0.01 ns, at most 1e9
    localparam int PROD_W     = 39;  // ns * 100
    localparam int DIV_NW     = 40;  // divider dividend / quotient
    localparam int DIV_DW     = 30;  // divider divisor / remainder
    localparam int DIV_CW     = 6;   // divider bit counter

    // Scaling constants
    localparam logic [CLK_W-1:0] CLOCK_RESET = 30'd100000000;
    localparam logic [CLK_W-1:0] NS_PER_S    = 30'd1000000000;
    localparam int               SCALE       = 100;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PERIOD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUTY   = 2'd2;

    // Control word bits
    localparam int CTRL_ENABLE_BIT = 0;
    localparam int CTRL_INVERT_BIT = 1;

    // x * 100 as shift-and-add: 64x + 32x + 4x
    function automatic logic [PROD_W-1:0] times_scale(input logic [NS_W-1:0] x);
        logic [PROD_W-1:0] xe;
        xe = PROD_W'(x);
        return (xe << 6) + (xe << 5) + (xe << 2);
    endfunction

endpackage

@@ design/pwm_timing_register_calc_unit.sv @@
// ============================================================================
// PWM timing register calculator
// Turns a period/duty request in ns into prescaler shift, period count and
// duty register value for the configured counter clock.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ------------------------------
//  config    in         i_cfg_wr_en                i_cfg_wr_data (clock rate, Hz)
//  request   in         start & !busy              period, duty, enable, inverted
//  result    out        o_result_valid (1 cycle)   status, counts, shift, control
//
//  All divisions go through one bit-serial restoring divider, one quotient
//  bit per cycle. A request divides clock/100 first, then the tick and period
//  count for each prescaler shift tried, and last the duty count.
//  Reset is synchronous, active low, and restores the clock rate to 100 MHz.
//  busy is high from the accepting edge until the result strobe; the
//  receiver cannot stall, each result shows for exactly one cycle.
// ============================================================================
module pwm_timing_register_calc_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [ptrc_pkg::CLK_W-1:0]        i_cfg_wr_data,
    // request
    input  logic                              start,
    output logic                              busy,
    input  logic [ptrc_pkg::NS_W-1:0]         i_period_ns,
    input  logic [ptrc_pkg::NS_W-1:0]         i_duty_ns,
    input  logic                              i_enable,
    input  logic                              i_inverted,
    // result
    output logic                              o_result_valid,
    output logic [ptrc_pkg::STATUS_W-1:0]     o_status,
    output logic [ptrc_pkg::PCOUNT_W-1:0]     o_period_count,
    output logic [ptrc_pkg::DCOUNT_W-1:0]     o_duty_count,
    output logic [ptrc_pkg::SHIFT_W-1:0]      o_prescale_shift,
    output logic [ptrc_pkg::CTRL_W-1:0]       o_control_word
);

    localparam int NW  = ptrc_pkg::DIV_NW;
    localparam int DW  = ptrc_pkg::DIV_DW;
    localparam int CW  = ptrc_pkg::DIV_CW;
    localparam int BW  = ptrc_pkg::BASE_W;
    localparam int TW  = ptrc_pkg::TICK_W;
    localparam int PW  = ptrc_pkg::PROD_W;
    localparam int SW  = ptrc_pkg::SHIFT_W;
    localparam int PCW = ptrc_pkg::PCOUNT_W;
    localparam int DCW = ptrc_pkg::DCOUNT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_BASE     = 3'd1;
    localparam logic [2:0] S_TICK_SET = 3'd2;
    localparam logic [2:0] S_TICK_DIV = 3'd3;
    localparam logic [2:0] S_CNT_DIV  = 3'd4;
    localparam logic [2:0] S_NEXT     = 3'd5;
    localparam logic [2:0] S_DUTY_SET = 3'd6;
    localparam logic [2:0] S_DUTY_DIV = 3'd7;

    // Registers
    logic [2:0]                         r_state,   n_state;
    logic [ptrc_pkg::CLK_W-1:0]         r_clk_hz,  n_clk_hz;
    logic [PW-1:0]                      r_prod_p,  n_prod_p;
    logic [PW-1:0]                      r_prod_d,  n_prod_d;
    logic                               r_duty_eq, n_duty_eq;
    logic                               r_duty_zero, n_duty_zero;
    logic [ptrc_pkg::CTRL_W-1:0]        r_ctrl,    n_ctrl;
    logic [BW-1:0]                      r_base,    n_base;
    logic [SW-1:0]                      r_shift,   n_shift;
    logic [TW-1:0]                      r_tick,    n_tick;
    logic [PCW-1:0]                     r_cnt,     n_cnt;
    logic [NW-1:0]                      r_num,     n_num;
    logic [DW-1:0]                      r_rem,     n_rem;
    logic [DW-1:0]                      r_den,     n_den;
    logic [CW-1:0]                      r_bits,    n_bits;
    logic                               r_valid,   n_valid;
    logic [ptrc_pkg::STATUS_W-1:0]      r_status,  n_status;
    logic [PCW-1:0]                     r_out_pc,  n_out_pc;
    logic [DCW-1:0]                     r_out_dc,  n_out_dc;
    logic [SW-1:0]                      r_out_sh,  n_out_sh;
    logic [ptrc_pkg::CTRL_W-1:0]        r_out_cw,  n_out_cw;

    // Divider step
    logic [DW:0]                        rem_sh;
    logic [DW:0]                        rem_diff;
    logic                               div_ge;
    logic [NW-1:0]                      div_q;
    logic [DW-1:0]                      div_rem;
    logic                               div_last;

    // Operand prep
    logic [BW-1:0]                      d_shifted;
    logic [TW:0]                        tick_num;
    logic [TW-1:0]                      tick_q;
    logic [PW-1:0]                      cnt_num;
    logic [PW-1:0]                      duty_num;

    // One restoring step: bring in next dividend bit, subtract if it fits
    assign rem_sh   = {r_rem, r_num[NW-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign div_ge   = (rem_sh >= {1'b0, r_den});
    assign div_q    = {r_num[NW-2:0], div_ge};
    assign div_rem  = div_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
    assign div_last = (r_bits == CW'(1));

    // Rounded-division dividends: add half the divisor
    assign d_shifted = r_base >> r_shift;
    assign tick_num  = (TW+1)'(ptrc_pkg::NS_PER_S) + (TW+1)'(d_shifted[BW-1:1]);
    assign tick_q    = div_q[TW-1:0];
    assign cnt_num   = r_prod_p + PW'(tick_q[TW-1:1]);
    assign duty_num  = r_prod_d + PW'(r_tick[TW-1:1]);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clk_hz    = i_cfg_wr_en ? i_cfg_wr_data : r_clk_hz;
        n_prod_p    = r_prod_p;
        n_prod_d    = r_prod_d;
        n_duty_eq   = r_duty_eq;
        n_duty_zero = r_duty_zero;
        n_ctrl      = r_ctrl;
        n_base      = r_base;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_cnt       = r_cnt;
        n_num       = r_num;
        n_rem       = r_rem;
        n_den       = r_den;
        n_bits      = r_bits;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_out_pc    = r_out_pc;
        n_out_dc    = r_out_dc;
        n_out_sh    = r_out_sh;
        n_out_cw    = r_out_cw;

        // shared divider advances in every dividing state
        if (r_state == S_BASE || r_state == S_TICK_DIV ||
            r_state == S_CNT_DIV || r_state == S_DUTY_DIV) begin
            n_num  = div_q;
            n_rem  = div_rem;
            n_bits = r_bits - CW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_prod_p    = ptrc_pkg::times_scale(i_period_ns);
                    n_prod_d    = ptrc_pkg::times_scale(i_duty_ns);
                    n_duty_eq   = (i_duty_ns == i_period_ns);
                    n_duty_zero = (i_duty_ns == '0);
                    n_ctrl      = '0;
                    n_ctrl[ptrc_pkg::CTRL_ENABLE_BIT] = i_enable;
                    n_ctrl[ptrc_pkg::CTRL_INVERT_BIT] = i_inverted;
                    // clock / 100, dividend left-aligned
                    n_num  = NW'(r_clk_hz) << (NW - ptrc_pkg::CLK_W);
                    n_den  = DW'(ptrc_pkg::SCALE);
                    n_rem  = '0;
                    n_bits = CW'(ptrc_pkg::CLK_W);
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                if (div_last) begin
                    n_base  = div_q[BW-1:0];
                    n_shift = '0;
                    n_state = S_TICK_SET;
                end
            end
            S_TICK_SET: begin
                // zero prescaled rate: this shift is out of range
                if (d_shifted == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_num   = NW'(tick_num) << (NW - (TW + 1));
                    n_den   = DW'(d_shifted);
                    n_rem   = '0;
                    n_bits  = CW'(TW + 1);
                    n_state = S_TICK_DIV;
                end
            end
            S_TICK_DIV: begin
                if (div_last) begin
                    if (tick_q == '0) begin
                        n_state = S_NEXT;
                    end else begin
                        n_tick  = tick_q;
                        n_num   = NW'(cnt_num) << (NW - PW);
                        n_den   = DW'(tick_q);
                        n_rem   = '0;
                        n_bits  = CW'(PW);
                        n_state = S_CNT_DIV;
                    end
                end
            end
            S_CNT_DIV: begin
                if (div_last) begin
                    if (div_q <= NW'(ptrc_pkg::COUNT_MAX)) begin
                        n_cnt   = div_q[PCW-1:0];
                        n_state = S_DUTY_SET;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                if (r_shift == SW'(ptrc_pkg::MAX_SHIFT - 1)) begin
                    // no shift fits
                    n_valid  = 1'b1;
                    n_status = ptrc_pkg::ST_PERIOD;
                    n_out_pc = '0;
                    n_out_dc = '0;
                    n_out_sh = '0;
                    n_out_cw = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_shift = r_shift + SW'(1);
                    n_state = S_TICK_SET;
                end
            end
            S_DUTY_SET: begin
                if (r_duty_eq || r_duty_zero) begin
                    n_valid  = 1'b1;
                    n_status = ptrc_pkg::ST_OK;
                    n_out_pc = r_cnt;
                    n_out_dc = r_duty_eq ? DCW'(r_cnt) : '0;
                    n_out_sh = r_shift;
                    n_out_cw = r_ctrl;
                    n_state  = S_IDLE;
                end else begin
                    n_num   = NW'(duty_num) << (NW - PW);
                    n_den   = DW'(r_tick);
                    n_rem   = '0;
                    n_bits  = CW'(PW);
                    n_state = S_DUTY_DIV;
                end
            end
            S_DUTY_DIV: begin
                if (div_last) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (div_q > NW'(ptrc_pkg::COUNT_MAX)) begin
                        n_status = ptrc_pkg::ST_DUTY;
                        n_out_pc = '0;
                        n_out_dc = '0;
                        n_out_sh = '0;
                        n_out_cw = '0;
                    end else begin
                        // count minus duty count, wrapped
                        n_status = ptrc_pkg::ST_OK;
                        n_out_pc = r_cnt;
                        n_out_dc = DCW'(r_cnt) - DCW'(div_q[PCW-1:0]);
                        n_out_sh = r_shift;
                        n_out_cw = r_ctrl;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_clk_hz <= ptrc_pkg::CLOCK_RESET;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_clk_hz <= n_clk_hz;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod_p    <= n_prod_p;
        r_prod_d    <= n_prod_d;
        r_duty_eq   <= n_duty_eq;
        r_duty_zero <= n_duty_zero;
        r_ctrl      <= n_ctrl;
        r_base      <= n_base;
        r_shift     <= n_shift;
        r_tick      <= n_tick;
        r_cnt       <= n_cnt;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_bits      <= n_bits;
        r_status    <= n_status;
        r_out_pc    <= n_out_pc;
        r_out_dc    <= n_out_dc;
        r_out_sh    <= n_out_sh;
        r_out_cw    <= n_out_cw;
    end

    // Outputs
    assign busy             = (r_state != S_IDLE);
    assign o_result_valid   = r_valid;
    assign o_status         = r_status;
    assign o_period_count   = r_out_pc;
    assign o_duty_count     = r_out_dc;
    assign o_prescale_shift = r_out_sh;
    assign o_control_word   = r_out_cw;

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ptrc_pkg::ST_OK) |->
        (o_period_count == '0 && o_duty_count == '0 &&
         o_prescale_shift == '0 && o_control_word == '0))
        else $error("error result carries nonzero fields");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_prescale_shift < SW'(ptrc_pkg::MAX_SHIFT - 1) ||
                            o_prescale_shift == SW'(ptrc_pkg::MAX_SHIFT - 1)))
        else $error("prescale shift beyond search limit");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BASE || r_state == S_TICK_DIV ||
         r_state == S_CNT_DIV || r_state == S_DUTY_DIV) |-> (r_bits != '0))
        else $error("divider running with no bits left");

endmodule

@@ dv/ptrc_result_checker.sv @@
// ============================================================================
// PWM timing register calculator - result checker
// Watches the config, request and result channels of the calculator, keeps
// its own copy of the clock-rate register, predicts every result on request
// transfer and compares each result strobe field by field with the oldest
// prediction. Hands the failure count and the number of open predictions up.
// ============================================================================
module ptrc_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [ptrc_pkg::CLK_W-1:0]        i_cfg_wr_data,
    // request
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [ptrc_pkg::NS_W-1:0]         i_period_ns,
    input  logic [ptrc_pkg::NS_W-1:0]         i_duty_ns,
    input  logic                              i_enable,
    input  logic                              i_inverted,
    // result
    input  logic                              i_result_valid,
    input  logic [ptrc_pkg::STATUS_W-1:0]     i_status,
    input  logic [ptrc_pkg::PCOUNT_W-1:0]     i_period_count,
    input  logic [ptrc_pkg::DCOUNT_W-1:0]     i_duty_count,
    input  logic [ptrc_pkg::SHIFT_W-1:0]      i_prescale_shift,
    input  logic [ptrc_pkg::CTRL_W-1:0]       i_control_word,
    // status
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [ptrc_pkg::STATUS_W-1:0] status;
        logic [ptrc_pkg::PCOUNT_W-1:0] period_count;
        logic [ptrc_pkg::DCOUNT_W-1:0] duty_count;
        logic [ptrc_pkg::SHIFT_W-1:0]  prescale_shift;
        logic [ptrc_pkg::CTRL_W-1:0]   control_word;
    } t_pwm_regs;

    logic [ptrc_pkg::CLK_W-1:0] clock_hz;
    t_pwm_regs                  expected_regs_q[$];
    int                         fail_cnt = 0;
    int                         open_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = open_cnt;

    // Search the prescaler shifts upward, then derive the duty register
    function automatic t_pwm_regs calc_pwm_regs(
        input logic [ptrc_pkg::CLK_W-1:0] clk_hz,
        input logic [ptrc_pkg::NS_W-1:0]  period_ns,
        input logic [ptrc_pkg::NS_W-1:0]  duty_ns,
        input logic                       en,
        input logic                       inv);
        logic [63:0]                  base;
        logic [63:0]                  rate;
        logic [63:0]                  tick;
        logic [63:0]                  cnt;
        logic [63:0]                  fit_tick;
        logic [63:0]                  fit_cnt;
        logic [63:0]                  duty_ticks;
        logic [63:0]                  duty_value;
        logic [ptrc_pkg::SHIFT_W-1:0] fit_shift;
        logic                         found;
        t_pwm_regs                    regs;

        regs       = '0;
        found      = 1'b0;
        fit_tick   = '0;
        fit_cnt    = '0;
        fit_shift  = '0;
        duty_value = '0;
        base       = 64'(clk_hz) / ptrc_pkg::SCALE;

        for (int s = 0; s < ptrc_pkg::MAX_SHIFT && !found; s++) begin
            rate = base >> s;
            // a zero rate or a zero tick cannot carry a count
            if (rate != 0) begin
                tick = (64'(ptrc_pkg::NS_PER_S) + rate / 2) / rate;
                if (tick != 0) begin
                    cnt = (64'(period_ns) * ptrc_pkg::SCALE + tick / 2) / tick;
                    if (cnt <= ptrc_pkg::COUNT_MAX) begin
                        found     = 1'b1;
                        fit_tick  = tick;
                        fit_cnt   = cnt;
                        fit_shift = ptrc_pkg::SHIFT_W'(s);
                    end
                end
            end
        end

        if (!found) begin
            regs.status = ptrc_pkg::ST_PERIOD;
            return regs;
        end

        if (duty_ns == period_ns) begin
            duty_value = fit_cnt;
        end else if (duty_ns != 0) begin
            duty_ticks = (64'(duty_ns) * ptrc_pkg::SCALE + fit_tick / 2) / fit_tick;
            if (duty_ticks > ptrc_pkg::COUNT_MAX) begin
                regs.status = ptrc_pkg::ST_DUTY;
                return regs;
            end
            duty_value = fit_cnt - duty_ticks;
        end

        regs.status         = ptrc_pkg::ST_OK;
        regs.period_count   = fit_cnt[ptrc_pkg::PCOUNT_W-1:0];
        regs.duty_count     = duty_value[ptrc_pkg::DCOUNT_W-1:0];
        regs.prescale_shift = fit_shift;
        regs.control_word[ptrc_pkg::CTRL_ENABLE_BIT] = en;
        regs.control_word[ptrc_pkg::CTRL_INVERT_BIT] = inv;
        return regs;
    endfunction

    // Track the register, predict on request transfer, compare on strobe
    always @(posedge i_clk) begin
        t_pwm_regs got;
        t_pwm_regs want;

        if (!i_rst_n) begin
            clock_hz <= ptrc_pkg::CLOCK_RESET;
            expected_regs_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                clock_hz <= i_cfg_wr_data;
            end
            if (i_start && !i_busy) begin
                expected_regs_q.push_back(calc_pwm_regs(clock_hz, i_period_ns, i_duty_ns,
                                                        i_enable, i_inverted));
            end
            if (i_result_valid) begin
                got = '{i_status, i_period_count, i_duty_count, i_prescale_shift,
                        i_control_word};
                if (expected_regs_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX) begin
                        $display("%0t: result transfer with no request open: st=%0d",
                                 $realtime, got.status);
                    end
                end else begin
                    want = expected_regs_q.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX) begin
                            $display("%0t: mismatch st %0d/%0d pcnt %0d/%0d dcnt %0d/%0d",
                                     $realtime, want.status, got.status,
                                     want.period_count, got.period_count,
                                     want.duty_count, got.duty_count);
                            $display("    (exp/act) shift %0d/%0d ctrl %0d/%0d",
                                     want.prescale_shift, got.prescale_shift,
                                     want.control_word, got.control_word);
                        end
                    end
                end
            end
        end
        open_cnt = expected_regs_q.size();
    end

endmodule

@@ dv/pwm_timing_register_calc_unit_tb.sv @@
// ============================================================================
// PWM timing register calculator - testbench top
// Drives directed and random period/duty requests through several clock-rate
// settings (extremes, zero and sub-100 Hz rates included) with random idle
// gaps and back-to-back bursts. A checker beside the block predicts and
// compares every result; this top only makes stimulus and gives the verdict.
// ============================================================================
module pwm_timing_register_calc_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;  // cycles with no transfer at all

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [ptrc_pkg::CLK_W-1:0]    cfg_wr_data = '0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [ptrc_pkg::NS_W-1:0]     period_ns = '0;
    logic [ptrc_pkg::NS_W-1:0]     duty_ns = '0;
    logic                          enable = 1'b0;
    logic                          inverted = 1'b0;
    logic                          result_valid;
    logic [ptrc_pkg::STATUS_W-1:0] status;
    logic [ptrc_pkg::PCOUNT_W-1:0] period_count;
    logic [ptrc_pkg::DCOUNT_W-1:0] duty_count;
    logic [ptrc_pkg::SHIFT_W-1:0]  prescale_shift;
    logic [ptrc_pkg::CTRL_W-1:0]   control_word;
    int                            fail_count;
    int                            pending;
    int                            burst_left = 0;
    int                            idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pwm_timing_register_calc_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .start            (start),
        .busy             (busy),
        .i_period_ns      (period_ns),
        .i_duty_ns        (duty_ns),
        .i_enable         (enable),
        .i_inverted       (inverted),
        .o_result_valid   (result_valid),
        .o_status         (status),
        .o_period_count   (period_count),
        .o_duty_count     (duty_count),
        .o_prescale_shift (prescale_shift),
        .o_control_word   (control_word)
    );

    ptrc_result_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_start          (start),
        .i_busy           (busy),
        .i_period_ns      (period_ns),
        .i_duty_ns        (duty_ns),
        .i_enable         (enable),
        .i_inverted       (inverted),
        .i_result_valid   (result_valid),
        .i_status         (status),
        .i_period_count   (period_count),
        .i_duty_count     (duty_count),
        .i_prescale_shift (prescale_shift),
        .i_control_word   (control_word),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // One request transfer: optional idle gap, then hold start until taken
    task automatic send_request(input logic [ptrc_pkg::NS_W-1:0] p,
                                input logic [ptrc_pkg::NS_W-1:0] d,
                                input logic en, input logic inv);
        int gap;

        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0) begin
                burst_left = $urandom_range(10, 40);
            end
        end
        @(negedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        period_ns <= p;
        duty_ns   <= d;
        enable    <= en;
        inverted  <= inv;
        // busy only moves on rising edges, so the falling-edge value holds
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    // Random requests: log-spread periods, duty biased toward the rule's cases
    task automatic send_random(input int n);
        int          mag;
        int          pick;
        logic [31:0] p;
        logic [31:0] d;

        for (int i = 0; i < n; i++) begin
            mag = $urandom_range(0, 32);
            p = (mag == 32) ? $urandom : ($urandom & ((32'd1 << mag) - 1));
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                d = p;
            end else if (pick < 30) begin
                d = '0;
            end else if (pick < 70) begin
                d = $urandom_range(0, p);
            end else if (pick < 80) begin
                d = p + 32'($urandom_range(1, 100));
            end else begin
                mag = $urandom_range(0, 32);
                d = (mag == 32) ? $urandom : ($urandom & ((32'd1 << mag) - 1));
            end
            send_request(p, d, 1'($urandom), 1'($urandom));
        end
    endtask

    // Clock-rate write once the block has drained
    task automatic load_clock_rate(input logic [ptrc_pkg::CLK_W-1:0] hz);
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Watchdog: ends the run when no transfer happens for too long
    always @(posedge clk) begin
        if ((start && !busy) || result_valid || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset clock rate (100 MHz, 10 ns tick)
        send_request(32'd0, 32'd0, 1'b0, 1'b0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);  // no shift fits
        send_request(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
        send_request(32'd10234, 32'd10234, 1'b0, 1'b1);          // top count, shift 0
        send_request(32'd10235, 32'd5000, 1'b1, 1'b1);           // rounds over, shift 1
        send_request(32'd10230, 32'd0, 1'b0, 1'b0);
        send_request(32'd10000, 32'd20000, 1'b1, 1'b0);          // duty count too big
        send_request(32'd1000, 32'd1100, 1'b1, 1'b1);            // duty wraps below zero
        send_request(32'd1000, 32'd1, 1'b0, 1'b1);               // duty rounds to zero
        send_request(32'd1000, 32'd4, 1'b1, 1'b0);
        send_request(32'd1000, 32'd5, 1'b0, 1'b0);               // duty rounds half up
        send_request(32'd5, 32'd5, 1'b1, 1'b1);
        send_request(32'd4, 32'd2, 1'b0, 1'b1);                  // period rounds to zero
        send_request(32'd4, 32'd9, 1'b1, 1'b1);
        send_request(32'd20000000, 32'd10000000, 1'b1, 1'b0);    // top shift
        send_request(32'd20000000, 32'd30000000, 1'b0, 1'b1);    // duty error, top shift
        send_request(32'd21000000, 32'd1000, 1'b1, 1'b1);        // just past every shift
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0);
        send_request(32'h0000_AAAA, 32'h0000_5555, 1'b1, 1'b0);
        send_request(32'h0000_5555, 32'h0000_5555, 1'b0, 1'b1);

        send_random(300);
        load_clock_rate(ptrc_pkg::CLK_W'(100));          // lowest usable rate, shift 0 only
        send_random(80);
        load_clock_rate(ptrc_pkg::CLK_W'(1000000000));   // 1 GHz
        send_random(150);
        load_clock_rate({ptrc_pkg::CLK_W{1'b1}});        // all register bits set
        send_random(80);
        load_clock_rate('0);                             // zero rate, always out of range
        send_random(25);
        load_clock_rate(ptrc_pkg::CLK_W'(99));           // below 100 Hz
        send_random(25);
        load_clock_rate(ptrc_pkg::CLK_W'(32768));
        send_random(100);
        load_clock_rate(ptrc_pkg::CLOCK_RESET);
        send_random(100);
        load_clock_rate(ptrc_pkg::CLK_W'(133333333));
        send_random(100);
        repeat (3) begin
            load_clock_rate(ptrc_pkg::CLK_W'($urandom_range(100, 1073741823)));
            send_random(60);
        end

        // drain, then a short settle
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
